FILE: rtl/lhr_pkg.sv
// lhr_pkg: types and constants for the link handshake responder
// no dependencies; imported by lhr_core, link_handshake_responder and the bench
`default_nettype none
package lhr_pkg;

	localparam int WordW     = 16;
	localparam int StateW    = 8;
	localparam int RetryW    = 4;
	localparam int SeenW     = 2;
	localparam int InDataW   = 40;
	localparam int OutDataW  = 40;

	localparam logic [7:0] HI_DETECT   = 8'h62;
	localparam logic [7:0] HI_IDENT    = 8'h72;
	localparam logic [7:0] HI_BLOCK    = 8'h63;
	localparam logic [7:0] LOOP_WRAP   = 8'hC4;
	localparam logic [7:0] LOOP_BLOCK  = 8'hD0;
	localparam logic [7:0] LOOP_START  = 8'h00;
	localparam logic [7:0] LOOP_IDENT  = 8'h01;
	localparam logic [7:0] LOOP_SYNC   = 8'h02;
	localparam logic [7:0] LOOP_STEP   = 8'h02;
	localparam logic [3:0] RETRY_FULL  = 4'hF;
	localparam logic [7:0] MASK_MASTER = 8'h01;
	localparam logic [7:0] MASK_SLAVE  = 8'h02;

	typedef struct packed {
		logic [WordW-1:0] partner_word;
		logic             partner_valid;
		logic [WordW-1:0] rx_word;
	} item_t;

	typedef struct packed {
		logic             block_phase;
		logic             entered_loop;
		logic             entered_block;
		logic [WordW-1:0] relay_word;
		logic             relay_valid;
		logic             partner_taken;
		logic [WordW-1:0] tx_word;
	} result_t;

	typedef struct packed {
		logic              phase_flag;
		logic [StateW-1:0] loop_state;
		logic [RetryW-1:0] retry_count;
		logic [SeenW-1:0]  peer_seen;
		logic [WordW-1:0]  peer_ident;
	} hs_state_t;

endpackage
`default_nettype wire

FILE: rtl/lhr_core.sv
// lhr_core: handshake state registers and the per-beat update logic
// depends on lhr_pkg
`default_nettype none
module lhr_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic            is_slave,
	input  wire lhr_pkg::item_t  item,
	output lhr_pkg::result_t     result
);
	import lhr_pkg::*;

	hs_state_t st_q;
	hs_state_t st_d;

	logic [7:0]  own;
	logic [7:0]  peer;
	logic [7:0]  rx_hi;
	logic [7:0]  rx_lo;
	logic [7:0]  loop_hi;
	logic [7:0]  next_loop;
	logic [SeenW-1:0] seen_new;

	always_comb begin
		own   = is_slave ? MASK_SLAVE : MASK_MASTER;
		peer  = is_slave ? MASK_MASTER : MASK_SLAVE;
		rx_hi = item.rx_word[15:8];
		rx_lo = item.rx_word[7:0];
		next_loop = st_q.loop_state + LOOP_STEP;
		seen_new = st_q.peer_seen | peer[SeenW-1:0];
		if (st_q.loop_state == LOOP_START) begin
			loop_hi = HI_DETECT;
		end else if (st_q.loop_state == LOOP_IDENT || st_q.loop_state == LOOP_SYNC) begin
			loop_hi = HI_IDENT;
		end else begin
			loop_hi = HI_DETECT - {1'b0, st_q.loop_state[7:1]};
		end
	end

	always_comb begin
		st_d   = st_q;
		result = '0;
		if (st_q.phase_flag) begin
			result.tx_word       = item.partner_valid ? item.partner_word : st_q.peer_ident;
			result.partner_taken = item.partner_valid;
			result.relay_valid   = 1'b1;
			result.relay_word    = item.rx_word;
			if (rx_hi == HI_DETECT) begin
				st_d.loop_state  = LOOP_START;
				st_d.retry_count = RETRY_FULL;
				st_d.peer_seen   = '0;
				st_d.phase_flag  = 1'b0;
				result.entered_loop = 1'b1;
			end
		end else begin
			result.tx_word = {loop_hi, own};
			if (st_q.loop_state == LOOP_START) begin
				if (st_q.retry_count != '0) begin
					st_d.retry_count = st_q.retry_count - 1'b1;
				end else begin
					st_d.loop_state  = LOOP_IDENT;
					st_d.peer_seen   = '0;
					st_d.retry_count = RETRY_FULL;
				end
			end else if (st_q.loop_state == LOOP_IDENT) begin
				if (rx_hi == HI_IDENT && rx_lo == peer) begin
					st_d.peer_seen  = seen_new;
					st_d.peer_ident = item.rx_word;
					st_d.loop_state = LOOP_SYNC;
				end else if (st_q.peer_seen != '0) begin
					st_d.loop_state = LOOP_SYNC;
				end
			end else begin
				st_d.loop_state = next_loop;
				if (next_loop >= LOOP_WRAP) begin
					st_d.loop_state  = LOOP_START;
					st_d.retry_count = RETRY_FULL;
					st_d.peer_seen   = '0;
				end
				if (rx_hi == HI_BLOCK) begin
					st_d.loop_state  = LOOP_BLOCK;
					st_d.phase_flag  = 1'b1;
					result.entered_block = 1'b1;
				end
			end
		end
		result.block_phase = st_d.phase_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase_flag  <= 1'b0;
			st_q.loop_state  <= LOOP_START;
			st_q.retry_count <= RETRY_FULL;
			st_q.peer_seen   <= '0;
			st_q.peer_ident  <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/link_handshake_responder.sv
// link_handshake_responder: top level, input register, output register, config
// depends on lhr_pkg and lhr_core
//
// usage:
// - s_* carries one beat per 16-bit serial exchange: rx_word, partner_valid,
//   partner_word; m_* returns one beat per input beat with the transmit word,
//   relay word and phase events
// - cfg_valid/cfg_data writes the is_slave role bit; cfg_ready is always high,
//   write it only while the block is idle
// - throughput: one beat per cycle while m_tready is high; the state update is one short
//   combinational step between the input register and the output register
// - s_tready stays high while the output register is empty or being taken;
//   when m_tready is low the output holds and the input register fills,
//   then s_tready drops, so no beat is lost or repeated
// - reset clears both registers, sets loop state 0, retry count 15, peer seen
//   0, stored peer word 0, loop phase, role master
`default_nettype none
module link_handshake_responder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// rx_word[15:0], partner_valid[16], partner_word[32:17], zero fill
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tx_word[15:0], partner_taken[16], relay_valid[17], relay_word[33:18],
	// entered_block[34], entered_loop[35], block_phase[36], zero fill
	output logic [39:0]      m_tdata
);
	import lhr_pkg::*;

	logic    is_slave_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res;
	logic    advance;
	logic    step;

	assign cfg_ready = 1'b1;
	assign advance   = !valid_s2 || m_tready;
	assign step      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_slave_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			is_slave_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_tdata[$bits(item_t)-1:0];
		end
	end

	lhr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.is_slave (is_slave_q),
		.item     (item_s1),
		.result   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_s2};

	a_events_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_s2.entered_block && res_s2.entered_loop))
		else $error("block and loop entry in the same beat");

	a_block_entry_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.entered_block) |-> res_s2.block_phase)
		else $error("block entry without block phase");

	a_loop_entry_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.entered_loop) |-> (!res_s2.block_phase && res_s2.relay_valid))
		else $error("loop entry with wrong phase or relay");

	a_relay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_s2.relay_valid) |-> (res_s2.relay_word == '0 && !res_s2.partner_taken))
		else $error("relay word or partner take outside block phase");

endmodule
`default_nettype wire

FILE: tb/link_handshake_responder_tb.sv
// link_handshake_responder_tb: self-checking bench for the link handshake responder
// drives exchange beats with random gaps and back-pressure, predicts every result beat
// depends on lhr_pkg and link_handshake_responder
`default_nettype none
module link_handshake_responder_tb;
	import lhr_pkg::*;

	localparam int CycleLimit  = 400000;
	localparam int HoldCycles  = 300;
	localparam int PhaseItems  = 450;
	localparam int DirRows     = 25;

	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} drow_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_data = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;

	// predictor state
	logic              role_slave;
	logic              in_block;
	logic [StateW-1:0] loop_st;
	logic [RetryW-1:0] retry;
	logic [SeenW-1:0]  seen;
	logic [WordW-1:0]  peer_word;
	logic [StateW-1:0] sync_goal = 8'hFF;

	result_t due_results [$];
	drow_t   dir_rows [DirRows];
	int      mismatches = 0;
	int      cycles = 0;
	int      src_idle = 0;
	int      dst_idle = 0;
	int      hold_req = 0;
	int      hold_seen = 0;
	int      hold_left = 0;

	link_handshake_responder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report(string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [WordW-1:0] got, logic [WordW-1:0] want);
		if (got !== want)
			report($sformatf("%s got %h want %h", name, got, want));
	endtask

	function void reopen_loop();
		loop_st = LOOP_START;
		retry = RETRY_FULL;
		seen = '0;
	endfunction

	// one serial exchange: transmit word from the old state, then the state update
	function automatic result_t exchange(item_t it);
		result_t r;
		logic [7:0] hi, own, peer;
		r = '0;
		hi = it.rx_word[15:8];
		own = role_slave ? MASK_SLAVE : MASK_MASTER;
		peer = role_slave ? MASK_MASTER : MASK_SLAVE;
		if (in_block) begin
			r.tx_word = it.partner_valid ? it.partner_word : peer_word;
			r.partner_taken = it.partner_valid;
			r.relay_valid = 1'b1;
			r.relay_word = it.rx_word;
			if (hi == HI_DETECT) begin
				reopen_loop();
				in_block = 1'b0;
				r.entered_loop = 1'b1;
			end
		end else begin
			if (loop_st == LOOP_START)
				r.tx_word = {HI_DETECT, own};
			else if (loop_st == LOOP_IDENT || loop_st == LOOP_SYNC)
				r.tx_word = {HI_IDENT, own};
			else
				r.tx_word = {HI_DETECT - {1'b0, loop_st[7:1]}, own};
			if (loop_st == LOOP_START) begin
				if (retry != 0) begin
					retry = retry - 1'b1;
				end else begin
					loop_st = LOOP_IDENT;
					seen = '0;
					retry = RETRY_FULL;
				end
			end else if (loop_st == LOOP_IDENT) begin
				if (hi == HI_IDENT && it.rx_word[7:0] == peer) begin
					seen = seen | peer[SeenW-1:0];
					peer_word = it.rx_word;
				end
				if (seen != 0)
					loop_st = LOOP_SYNC;
			end else begin
				loop_st = loop_st + LOOP_STEP;
				if (loop_st >= LOOP_WRAP)
					reopen_loop();
				if (hi == HI_BLOCK) begin
					loop_st = LOOP_BLOCK;
					in_block = 1'b1;
					r.entered_block = 1'b1;
				end
			end
		end
		r.block_phase = in_block;
		return r;
	endfunction

	// mostly well-formed handshakes with random content, some plain noise
	function automatic item_t next_exchange();
		item_t it;
		logic [7:0] own, peer;
		it.rx_word = WordW'($urandom);
		it.partner_valid = 1'($urandom_range(1));
		it.partner_word = WordW'($urandom);
		if ($urandom_range(99) < 15)
			return it;
		own = role_slave ? MASK_SLAVE : MASK_MASTER;
		peer = role_slave ? MASK_MASTER : MASK_SLAVE;
		if (in_block) begin
			if ($urandom_range(99) < 12)
				it.rx_word[15:8] = HI_DETECT;
			else if (it.rx_word[15:8] == HI_DETECT)
				it.rx_word[8] = ~it.rx_word[8];
		end else if (loop_st == LOOP_IDENT) begin
			case ($urandom_range(9))
				0, 1: it.rx_word = {HI_IDENT, own};
				2: ;
				default: it.rx_word = {HI_IDENT, peer};
			endcase
		end else if (loop_st != LOOP_START) begin
			if (loop_st == LOOP_SYNC) begin
				case ($urandom_range(9))
					0, 1, 2: sync_goal = 8'hFF;
					3: sync_goal = LOOP_WRAP - LOOP_STEP;
					default: sync_goal = 8'($urandom_range(1, 8'h61) * 2);
				endcase
			end
			if (loop_st >= sync_goal)
				it.rx_word[15:8] = HI_BLOCK;
			else if (it.rx_word[15:8] == HI_BLOCK)
				it.rx_word[8] = ~it.rx_word[8];
		end
		return it;
	endfunction

	function automatic drow_t row(logic [15:0] rx, logic pv, logic [15:0] pw, logic typed,
			logic [15:0] tx, logic pt, logic rv, logic [15:0] rw, logic eb, logic el, logic bp);
		drow_t d;
		d.stim = '{partner_word: pw, partner_valid: pv, rx_word: rx};
		d.typed = typed;
		d.want = '{block_phase: bp, entered_loop: el, entered_block: eb, relay_word: rw,
			relay_valid: rv, partner_taken: pt, tx_word: tx};
		return d;
	endfunction

	// offer one beat after a random gap, record its expected result on acceptance
	task automatic send_item(item_t it, logic typed, result_t want);
		result_t r;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= InDataW'(it);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = exchange(it);
		due_results.push_back(typed ? want : r);
	endtask

	task automatic wait_quiet(int extra);
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_role(logic slave);
		cfg_valid <= 1'b1;
		cfg_data <= slave;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		role_slave = slave;
	endtask

	always @(posedge clk) begin : drain
		result_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[$bits(result_t)-1:0];
			if (m_tdata[OutDataW-1:$bits(result_t)] !== '0)
				report("nonzero fill in result beat");
			if (due_results.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				want = due_results.pop_front();
				check_field("tx_word", got.tx_word, want.tx_word);
				check_field("partner_taken", WordW'(got.partner_taken),
					WordW'(want.partner_taken));
				check_field("relay_valid", WordW'(got.relay_valid),
					WordW'(want.relay_valid));
				check_field("relay_word", got.relay_word, want.relay_word);
				check_field("entered_block", WordW'(got.entered_block),
					WordW'(want.entered_block));
				check_field("entered_loop", WordW'(got.entered_loop),
					WordW'(want.entered_loop));
				check_field("block_phase", WordW'(got.block_phase),
					WordW'(want.block_phase));
			end
		end
		// long hold-off so the block backs up and drops s_tready
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HoldCycles;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= dst_idle);
		end
	end

	initial begin : run
		dir_rows = '{
			row(16'h0000, 1'b0, 16'h0000, 1'b1, 16'h6201, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'h6201, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h6300, 1'b0, 16'h0000, 1'b1, 16'h6201, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h0001, 1'b1, 16'h0001, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h8000, 1'b0, 16'h8000, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h7202, 1'b1, 16'h5555, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h6200, 1'b0, 16'hAAAA, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h7201, 1'b1, 16'h1234, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h5A5A, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'hA5A5, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h00FF, 1'b0, 16'h00FF, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'hFF00, 1'b1, 16'hFF00, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h63FF, 1'b0, 16'h0F0F, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h7FFF, 1'b1, 16'hF0F0, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h0000, 1'b0, 16'h0000, 1'b1, 16'h6201, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h7201, 1'b0, 16'h0000, 1'b1, 16'h7201, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h7202, 1'b0, 16'h0000, 1'b1, 16'h7201, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h0000, 1'b0, 16'h0000, 1'b1, 16'h7201, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'h6001, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0),
			row(16'h63FF, 1'b0, 16'h0000, 1'b1, 16'h5F01, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1),
			row(16'h0000, 1'b1, 16'hABCD, 1'b1, 16'hABCD, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1),
			row(16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 16'h7202, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1),
			row(16'h62FF, 1'b1, 16'h0000, 1'b1, 16'h0000, 1'b1, 1'b1, 16'h62FF, 1'b0, 1'b1, 1'b0),
			row(16'h0000, 1'b0, 16'h0000, 1'b1, 16'h6201, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0)
		};
		role_slave = 1'b0;
		in_block = 1'b0;
		reopen_loop();
		peer_word = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle = 38;
					dst_idle <= 88;
				end
				1: begin
					src_idle = 88;
					dst_idle <= 38;
				end
				default: begin
					src_idle = 0;
					dst_idle <= 0;
				end
			endcase
			wait_quiet(4);
			write_role(ph == 1);
			if (ph == 0) begin
				for (int k = 0; k < DirRows; k++)
					send_item(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);
			end
			if (ph == 2)
				hold_req <= hold_req + 1;
			repeat (PhaseItems) send_item(next_exchange(), 1'b0, '0);
		end
		wait_quiet(8);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
